// File: rtl/srts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted range table search core.
// No dependencies; every other file imports this package.
package srts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ENTRY_BYTES = 12;

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = IDX_W + 1;
  localparam int DATA_W   = 32;
  localparam int OFFS_W   = 34;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Read address source for the table memories.
  localparam logic [1:0] ADDR_HOLD   = 2'd0;
  localparam logic [1:0] ADDR_ZERO   = 2'd1;
  localparam logic [1:0] ADDR_FIRST  = 2'd2;
  localparam logic [1:0] ADDR_SEARCH = 2'd3;

  typedef struct packed {
    logic       wr_en;
    logic       start;
    logic [1:0] addr_sel;
    logic       init;
    logic       step;
    logic       set_miss;
    logic       set_result;
    logic       load_out;
  } srts_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic key_below;
    logic search_done;
    logic out_free;
  } srts_stat_t;

endpackage

// File: rtl/srts_in_if.sv
`timescale 1ns / 1ps
// Input channel of the search core: valid/ready plus one item.
// Depends on srts_pkg for field widths.
interface srts_in_if
  import srts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [IDX_W-1:0]  entry_slot;
  logic [DATA_W-1:0] range_start;
  logic [DATA_W-1:0] range_end;
  logic [DATA_W-1:0] search_key;

  modport source (output valid, operation, entry_slot, range_start, range_end, search_key,
                  input ready);
  modport sink   (input valid, operation, entry_slot, range_start, range_end, search_key,
                  output ready);
endinterface

// File: rtl/srts_out_if.sv
`timescale 1ns / 1ps
// Result channel of the search core: valid/ready plus one result.
// Depends on srts_pkg for field widths.
interface srts_out_if
  import srts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [IDX_W-1:0]  hit_index;
  logic [OFFS_W-1:0] hit_offset;

  modport source (output valid, hit, hit_index, hit_offset, input ready);
  modport sink   (input valid, hit, hit_index, hit_offset, output ready);
endinterface

// File: rtl/srts_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, range tables, search bounds and result register.
// Depends on srts_pkg; driven by commands from srts_ctrl.
module srts_dp
  import srts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic [IDX_W-1:0]     in_slot,
  input  logic [DATA_W-1:0]    in_start,
  input  logic [DATA_W-1:0]    in_end,
  input  logic [DATA_W-1:0]    in_key,
  input  srts_cmd_t            cmd,
  output srts_stat_t           stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [IDX_W-1:0]     out_hit_index,
  output logic [OFFS_W-1:0]    out_hit_offset
);

  logic [DATA_W-1:0] start_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] end_mem   [TABLE_DEPTH];

  logic [CNT_W-1:0]  entry_count_r;
  logic [DATA_W-1:0] table_base_r;
  logic [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  lo_r, hi_r;
  logic [IDX_W-1:0]  rd_addr_r;
  logic [DATA_W-1:0] rd_start_r, rd_end_r;
  logic              res_hit_r;
  logic [IDX_W-1:0]  res_index_r;
  logic [OFFS_W-1:0] res_offset_r;
  logic              out_valid_r;
  logic              out_hit_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [OFFS_W-1:0] out_offset_r;

  logic              key_lt, key_gt, key_eq;
  logic [IDX_W-1:0]  raddr;
  logic [CNT_W-1:0]  lo_nxt, hi_nxt, cnt_sat;
  logic [CNT_W:0]    bound_sum;
  logic [IDX_W-1:0]  next_mid, found;
  logic              done;
  logic              in_range;

  always_comb begin
    cnt_sat = (entry_count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count_r;
  end

  // One probe per cycle: compare the key with the entry just read and narrow the bounds.
  always_comb begin
    key_lt    = key_r < rd_start_r;
    key_gt    = rd_start_r < key_r;
    key_eq    = !key_lt && !key_gt;
    lo_nxt    = key_gt ? CNT_W'(rd_addr_r) : lo_r;
    hi_nxt    = key_lt ? CNT_W'(rd_addr_r) : hi_r;
    bound_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    next_mid  = bound_sum[IDX_W:1];
    done      = key_eq || (({1'b0, lo_nxt} + (CNT_W+1)'(1)) >= {1'b0, hi_nxt});
    found     = key_eq ? rd_addr_r : lo_nxt[IDX_W-1:0];
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_ZERO:   raddr = '0;
      ADDR_FIRST:  raddr = cnt_r[IDX_W:1];
      ADDR_SEARCH: raddr = done ? found : next_mid;
      default:     raddr = rd_addr_r;
    endcase
  end

  always_comb begin
    in_range = (rd_start_r <= key_r) && (key_r < rd_end_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      start_mem[in_slot] <= in_start;
      end_mem[in_slot]   <= in_end;
    end
    rd_start_r <= start_mem[raddr];
    rd_end_r   <= end_mem[raddr];
    rd_addr_r  <= raddr;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_key;
      cnt_r <= cnt_sat;
    end
    if (cmd.init) begin
      lo_r <= '0;
      hi_r <= cnt_r;
    end else if (cmd.step) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.set_miss) begin
      res_hit_r    <= 1'b0;
      res_index_r  <= '0;
      res_offset_r <= '0;
    end else if (cmd.set_result) begin
      res_hit_r    <= in_range;
      res_index_r  <= in_range ? rd_addr_r : '0;
      res_offset_r <= in_range ? (OFFS_W'(table_base_r) +
                                  OFFS_W'(rd_addr_r) * OFFS_W'(ENTRY_BYTES)) : '0;
    end
    if (cmd.load_out) begin
      out_hit_r    <= res_hit_r;
      out_index_r  <= res_index_r;
      out_offset_r <= res_offset_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      table_base_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[CNT_W-1:0];
          CFG_TABLE_BASE:  table_base_r  <= cfg_wdata;
          default:         ;
        endcase
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.count_zero  = (entry_count_r == '0);
    stat.key_below   = key_lt;
    stat.search_done = done;
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_hit_index  = out_index_r;
  assign out_hit_offset = out_offset_r;

endmodule

// File: rtl/srts_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences table writes and lookups.
// Depends on srts_pkg; drives srts_dp through the command struct.
module srts_ctrl
  import srts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  srts_stat_t stat,
  output srts_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_FINAL  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start    = 1'b1;
            cmd.addr_sel = ADDR_ZERO;
            if (stat.count_zero) begin
              cmd.set_miss = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        if (stat.key_below) begin
          cmd.set_miss = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.init     = 1'b1;
          cmd.addr_sel = ADDR_FIRST;
          state_nxt    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step     = 1'b1;
        cmd.addr_sel = ADDR_SEARCH;
        if (stat.search_done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.set_result = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/sorted_range_table_search_core.sv
`timescale 1ns / 1ps
// Top level of the sorted range table search core.
// Depends on srts_pkg, srts_in_if, srts_out_if, srts_ctrl and srts_dp.
//
// Usage: software sets entry_count (index 0) and table_base (index 1) over the
// cfg_ write port while the core is idle. Each transfer on the input channel is
// either a write item, which stores one range into the start and end tables at
// entry_slot, or a lookup item, which searches for search_key. Writes produce no
// result and are absorbed in the cycle of their transfer. Each lookup produces
// exactly one result transfer: hit, the entry index and the byte offset
// table_base + index * 12, or all zeros on a miss.
// Sequence: entry 0 is read first, then one probe per cycle narrows the bounds,
// then the range check runs and the output register is loaded. A key below the
// first start ends as a miss after the check of entry 0, and an empty table ends
// as a miss at once; the next input transfer can follow in the cycle after the
// output register is loaded.
// One lookup is in flight at a time; the next item is taken once the result sits
// in the output register. If the receiver stalls, the result waits there and a
// following lookup holds in its last state until the register frees up.
// Reset (synchronous, active low) clears the controller, the output valid flag
// and the configuration registers; the range tables keep undefined contents
// until written.
module sorted_range_table_search_core
  import srts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  srts_in_if.sink              in_ch,
  srts_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  srts_cmd_t  cmd;
  srts_stat_t stat;
  logic       in_ready;

  // The controller owns the input handshake; the datapath owns the tables, registers and output handshake.
  srts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_slot        (in_ch.entry_slot),
    .in_start       (in_ch.range_start),
    .in_end         (in_ch.range_end),
    .in_key         (in_ch.search_key),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_hit        (out_ch.hit),
    .out_hit_index  (out_ch.hit_index),
    .out_hit_offset (out_ch.hit_offset)
  );

  assign in_ch.ready = in_ready;

endmodule
